[design/udp_ipv4_header_builder_unit_macros.svh]
// Assertion macros for the UDP/IPv4 header builder.
`ifndef UDP_IPV4_HEADER_BUILDER_UNIT_MACROS_SVH
`define UDP_IPV4_HEADER_BUILDER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UHB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UHB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/uhb_pkg.sv]
// Package: types, constants and register codes of the UDP/IPv4 header builder.
package uhb_pkg;

  localparam int HDR_BYTES  = 42;
  localparam int HDR_BITS   = HDR_BYTES * 8;
  localparam int IDX_W      = 6;
  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 64;
  localparam int SUM_W      = 19;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_TOS        = 8'h00;
  localparam logic [15:0] IP_ID         = 16'h1234;
  localparam logic [15:0] IP_FRAG       = 16'h0000;
  localparam logic [7:0]  IP_TTL        = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [15:0] UDP_CSUM      = 16'h0000;
  localparam logic [15:0] IP_HDR_BYTES  = 16'd20;
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

  // Fixed words of the IPv4 header that enter the checksum.
  localparam logic [SUM_W-1:0] CSUM_FIXED =
      SUM_W'({IP_VER_IHL, IP_TOS}) + SUM_W'(IP_ID) + SUM_W'(IP_FRAG) +
      SUM_W'({IP_TTL, IP_PROTO_UDP});

  typedef enum logic [2:0] {
    REG_SRC_MAC  = 3'd0,
    REG_DST_MAC  = 3'd1,
    REG_SRC_IP   = 3'd2,
    REG_DST_IP   = 3'd3,
    REG_SRC_PORT = 3'd4,
    REG_DST_PORT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } cfg_t;

  typedef struct packed {
    logic             vld;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
  } cell_t;

endpackage

[design/uhb_if.sv]
// Channel interfaces: payload length requests and header byte results.
interface uhb_len_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_length;

  modport source (output valid, output payload_length, input ready);
  modport sink (input valid, input payload_length, output ready);
endinterface

interface uhb_byte_if;
  logic                     valid;
  logic                     ready;
  logic [7:0]               header_byte;
  logic [uhb_pkg::IDX_W-1:0] byte_index;
  logic                     last_byte;

  modport source (output valid, output header_byte, output byte_index, output last_byte,
                  input ready);
  modport sink (input valid, input header_byte, input byte_index, input last_byte,
                output ready);
endinterface

[design/uhb_regs.sv]
// APB register file holding the MAC, IP and port configuration.
module uhb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uhb_pkg::ADDR_W-1:0] paddr,
  input  logic [uhb_pkg::DATA_W-1:0] pwdata,
  output logic [uhb_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output uhb_pkg::cfg_t              cfg
);

  logic             wr_en;
  uhb_pkg::reg_idx_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = uhb_pkg::reg_idx_t'(paddr[uhb_pkg::ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (sel)
        uhb_pkg::REG_SRC_MAC:  cfg.source_mac  <= pwdata[47:0];
        uhb_pkg::REG_DST_MAC:  cfg.dest_mac    <= pwdata[47:0];
        uhb_pkg::REG_SRC_IP:   cfg.source_ip   <= pwdata[31:0];
        uhb_pkg::REG_DST_IP:   cfg.dest_ip     <= pwdata[31:0];
        uhb_pkg::REG_SRC_PORT: cfg.source_port <= pwdata[15:0];
        uhb_pkg::REG_DST_PORT: cfg.dest_port   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      uhb_pkg::REG_SRC_MAC:  prdata = uhb_pkg::DATA_W'(cfg.source_mac);
      uhb_pkg::REG_DST_MAC:  prdata = uhb_pkg::DATA_W'(cfg.dest_mac);
      uhb_pkg::REG_SRC_IP:   prdata = uhb_pkg::DATA_W'(cfg.source_ip);
      uhb_pkg::REG_DST_IP:   prdata = uhb_pkg::DATA_W'(cfg.dest_ip);
      uhb_pkg::REG_SRC_PORT: prdata = uhb_pkg::DATA_W'(cfg.source_port);
      uhb_pkg::REG_DST_PORT: prdata = uhb_pkg::DATA_W'(cfg.dest_port);
      default:               prdata = '0;
    endcase
  end

endmodule

[design/uhb_csum.sv]
// IPv4 header checksum: one's-complement sum of the header words, folded and inverted.
module uhb_csum (
  input  uhb_pkg::cfg_t cfg,
  input  logic [15:0]   total_len,
  output logic [15:0]   csum
);

  logic [uhb_pkg::SUM_W-1:0] sum;
  logic [16:0]               fold1;
  logic [16:0]               fold2;

  always_comb begin
    sum = uhb_pkg::CSUM_FIXED + uhb_pkg::SUM_W'(total_len) +
          uhb_pkg::SUM_W'(cfg.source_ip[31:16]) + uhb_pkg::SUM_W'(cfg.source_ip[15:0]) +
          uhb_pkg::SUM_W'(cfg.dest_ip[31:16]) + uhb_pkg::SUM_W'(cfg.dest_ip[15:0]);
    // Two folds suffice: the first leaves at most one carry.
    fold1 = 17'(sum[15:0]) + 17'(sum[uhb_pkg::SUM_W-1:16]);
    fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
    csum  = ~fold2[15:0];
  end

endmodule

[design/uhb_cell.sv]
// One cell of the byte shift line: takes a loaded byte or its neighbour's.
module uhb_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic           advance,
  input  uhb_pkg::cell_t load_val,
  input  uhb_pkg::cell_t from_next,
  output uhb_pkg::cell_t held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (load) begin
      held <= load_val;
    end else if (advance) begin
      held <= from_next;
    end
  end

endmodule

[design/udp_ipv4_header_builder_unit.sv]
// Top level: request stage, header assembly and the byte shift line.
// Each accepted payload length yields the 42-byte Ethernet/IPv4/UDP header, one byte per
// cycle while header.ready takes them; the 42-cell shift line moves the header towards
// the output one byte per advance. An accepted length is registered in the request stage
// and loads into the line once the line has drained to its head. The one-deep stage holds
// the next length and its checksum, so a following header loads into the line in the
// cycle its predecessor's last byte leaves and the output runs without gaps. Configuration
// is written over the APB port at byte address 8*index; write it only while idle.
`include "udp_ipv4_header_builder_unit_macros.svh"

module udp_ipv4_header_builder_unit (
  input  logic                       clk,
  input  logic                       rst,
  uhb_len_if.sink                    request,
  uhb_byte_if.source                 header,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uhb_pkg::ADDR_W-1:0] paddr,
  input  logic [uhb_pkg::DATA_W-1:0] pwdata,
  output logic [uhb_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  uhb_pkg::cfg_t cfg;

  logic        pend_vld;
  logic [15:0] pend_total;
  logic [15:0] pend_udp;
  logic [15:0] pend_csum;

  logic [15:0] in_total;
  logic [15:0] in_csum;
  logic        advance;
  logic        load;
  logic        req_take;

  logic [uhb_pkg::HDR_BITS-1:0] hdr;
  uhb_pkg::cell_t               cells [uhb_pkg::HDR_BYTES];

  uhb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_total = 16'(request.payload_length + uhb_pkg::IP_HDR_BYTES +
                        uhb_pkg::UDP_HDR_BYTES);

  uhb_csum u_csum (
    .cfg       (cfg),
    .total_len (in_total),
    .csum      (in_csum)
  );

  // Shift when the output is empty or taken; reload once the line drains to its head.
  assign advance       = !cells[0].vld || header.ready;
  assign load          = pend_vld && advance && !cells[1].vld;
  assign request.ready = !pend_vld || load;
  assign req_take      = request.valid && request.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
    end else if (req_take) begin
      pend_vld <= 1'b1;
    end else if (load) begin
      pend_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      pend_total <= in_total;
      pend_udp   <= 16'(request.payload_length + uhb_pkg::UDP_HDR_BYTES);
      pend_csum  <= in_csum;
    end
  end

  assign hdr = {cfg.dest_mac, cfg.source_mac, uhb_pkg::ETH_TYPE_IPV4,
                uhb_pkg::IP_VER_IHL, uhb_pkg::IP_TOS, pend_total, uhb_pkg::IP_ID,
                uhb_pkg::IP_FRAG, uhb_pkg::IP_TTL, uhb_pkg::IP_PROTO_UDP, pend_csum,
                cfg.source_ip, cfg.dest_ip, cfg.source_port, cfg.dest_port,
                pend_udp, uhb_pkg::UDP_CSUM};

  for (genvar i = 0; i < uhb_pkg::HDR_BYTES; i++) begin : g_cell
    uhb_pkg::cell_t load_val;
    uhb_pkg::cell_t from_next;

    assign load_val.vld  = 1'b1;
    assign load_val.data = hdr[uhb_pkg::HDR_BITS-1-8*i -: 8];
    assign load_val.idx  = uhb_pkg::IDX_W'(i);
    assign load_val.last = (i == uhb_pkg::HDR_BYTES - 1);

    if (i == uhb_pkg::HDR_BYTES - 1) begin : g_tail
      assign from_next = '0;
    end else begin : g_body
      assign from_next = cells[i+1];
    end

    uhb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (load),
      .advance   (advance),
      .load_val  (load_val),
      .from_next (from_next),
      .held      (cells[i])
    );
  end

  assign header.valid       = cells[0].vld;
  assign header.header_byte = cells[0].data;
  assign header.byte_index  = cells[0].idx;
  assign header.last_byte   = cells[0].last;

  `UHB_ASSERT_NOW(a_no_gap, clk, rst, header.valid && !header.last_byte, cells[1].vld,
                  "header byte shown with an empty cell behind it")

  `UHB_ASSERT_NEXT(a_index_step, clk, rst,
                   header.valid && header.ready && !header.last_byte,
                   header.valid &&
                   header.byte_index == uhb_pkg::IDX_W'($past(header.byte_index) + 1'b1),
                   "byte index did not advance by one")

  `UHB_ASSERT_NEXT(a_back_to_back, clk, rst,
                   header.valid && header.ready && header.last_byte && pend_vld,
                   header.valid && header.byte_index == '0,
                   "pending header did not follow the last byte")

endmodule

[sim/uhb_header_checker.sv]
// Header byte checker: follows requests and register writes, predicts and scores each header byte.
module uhb_header_checker (
  input  logic                       clk,
  input  logic                       rst,
  uhb_len_if                         req,
  uhb_byte_if                        hdr,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [uhb_pkg::ADDR_W-1:0] paddr,
  input  logic [uhb_pkg::DATA_W-1:0] pwdata,
  output int                         mismatches,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] ETHERTYPE   = 16'h0800;
  localparam logic [15:0] VER_IHL_TOS = 16'h4500;
  localparam logic [15:0] IDENT       = 16'h1234;
  localparam logic [15:0] FLAGS_FRAG  = 16'h0000;
  localparam logic [15:0] TTL_PROTO   = {8'd64, 8'd17};
  localparam logic [15:0] IP_OVERHEAD = 16'd28;
  localparam logic [15:0] UDP_OVERHEAD = 16'd8;

  typedef struct packed {
    logic [7:0]                data;
    logic [uhb_pkg::IDX_W-1:0] idx;
    logic                      last;
  } hdr_byte_t;

  hdr_byte_t     expected_bytes[$];
  uhb_pkg::cfg_t cfg;

  // Whole header image, wire byte 0 in the top bits.
  function automatic logic [uhb_pkg::HDR_BITS-1:0] build_header(input uhb_pkg::cfg_t c,
                                                                input logic [15:0] plen);
    logic [15:0] ip_len;
    logic [15:0] udp_len;
    logic [31:0] sum;
    logic [15:0] csum;
    ip_len  = plen + IP_OVERHEAD;
    udp_len = plen + UDP_OVERHEAD;
    sum = 32'(VER_IHL_TOS) + 32'(ip_len) + 32'(IDENT) + 32'(FLAGS_FRAG) + 32'(TTL_PROTO) +
          32'(c.source_ip[31:16]) + 32'(c.source_ip[15:0]) +
          32'(c.dest_ip[31:16]) + 32'(c.dest_ip[15:0]);
    // fold the carries back in until the sum fits in 16 bits
    while (sum[31:16] != 16'd0)
      sum = 32'(sum[15:0]) + 32'(sum[31:16]);
    csum = ~sum[15:0];
    return {c.dest_mac, c.source_mac, ETHERTYPE,
            VER_IHL_TOS, ip_len, IDENT, FLAGS_FRAG, TTL_PROTO, csum,
            c.source_ip, c.dest_ip,
            c.source_port, c.dest_port, udp_len, 16'h0000};
  endfunction

  always @(posedge clk) begin
    logic [uhb_pkg::HDR_BITS-1:0] image;
    hdr_byte_t                    got;
    hdr_byte_t                    want;
    if (rst) begin
      cfg = '0;
      expected_bytes.delete();
      mismatches = 0;
    end else begin
      if (req.valid && req.ready) begin
        image = build_header(cfg, req.payload_length);
        for (int i = 0; i < uhb_pkg::HDR_BYTES; i++)
          expected_bytes.push_back('{data: image[uhb_pkg::HDR_BITS-1-8*i -: 8],
                                     idx:  uhb_pkg::IDX_W'(i),
                                     last: (i == uhb_pkg::HDR_BYTES - 1)});
      end
      if (hdr.valid && hdr.ready) begin
        got = '{data: hdr.header_byte, idx: hdr.byte_index, last: hdr.last_byte};
        if (expected_bytes.size() == 0) begin
          $error("unexpected header byte 0x%02h at index %0d", got.data, got.idx);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (got.data !== want.data) begin
            $error("header_byte: expected 0x%02h, got 0x%02h", want.data, got.data);
            mismatches++;
          end
          if (got.idx !== want.idx) begin
            $error("byte_index: expected %0d, got %0d", want.idx, got.idx);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last_byte: expected %0b, got %0b", want.last, got.last);
            mismatches++;
          end
        end
      end
      // writes apply after the same edge's request; writing only while idle is the user's duty
      if (psel && penable && pwrite && pready) begin
        case (paddr[uhb_pkg::ADDR_W-1:3])
          uhb_pkg::REG_SRC_MAC:  cfg.source_mac  = pwdata[47:0];
          uhb_pkg::REG_DST_MAC:  cfg.dest_mac    = pwdata[47:0];
          uhb_pkg::REG_SRC_IP:   cfg.source_ip   = pwdata[31:0];
          uhb_pkg::REG_DST_IP:   cfg.dest_ip     = pwdata[31:0];
          uhb_pkg::REG_SRC_PORT: cfg.source_port = pwdata[15:0];
          uhb_pkg::REG_DST_PORT: cfg.dest_port   = pwdata[15:0];
          default: ;
        endcase
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

[sim/tb.sv]
// Testbench top for the header builder: clock, reset, register writes, requests and the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RUN_LIMIT       = 1_000_000;
  localparam int          PHASES          = 6;
  localparam int          ITEMS_PER_PHASE = 66;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          MAX_IDLE        = 6;
  localparam logic [2:0]  SPARE_REG_LO    = 3'd6;
  localparam logic [2:0]  SPARE_REG_HI    = 3'd7;
  localparam logic [15:0] MAX_PAYLOAD     = 16'd65507;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [uhb_pkg::ADDR_W-1:0] paddr;
  logic [uhb_pkg::DATA_W-1:0] pwdata;
  logic [uhb_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  bit                         tx_quiet;
  bit                         rx_quiet;
  int                         mismatches;
  int                         pending;
  int                         cycle_count = 0;

  uhb_len_if  req_ch ();
  uhb_byte_if hdr_ch ();

  udp_ipv4_header_builder_unit uut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .header  (hdr_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  uhb_header_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .hdr        (hdr_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Byte sink: unless rx_quiet, hold ready low for a random stall before each transaction.
  initial begin
    int stall;
    hdr_ch.ready = 1'b0;
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        hdr_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hdr_ch.ready <= 1'b1;
      do @(posedge clk); while (!(hdr_ch.valid && hdr_ch.ready));
    end
  end

  // Setup phase, access phase held until pready, then the bus goes idle.
  task automatic reg_write(input logic [2:0] reg_sel,
                           input logic [uhb_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // After a random idle gap unless tx_quiet, present one payload length and hold it until accepted.
  task automatic send_length(input logic [15:0] len);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      req_ch.valid          <= 1'b0;
      req_ch.payload_length <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.payload_length <= len;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid and wait until every predicted header byte has been seen.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [uhb_pkg::DATA_W-1:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom_range(0, 64));
      2:       return 16'($urandom_range(65500, 65535));
      3:       return 16'($urandom);
      default: return 16'($urandom_range(0, MAX_PAYLOAD));
    endcase
  endfunction

  task automatic load_random_config();
    uhb_pkg::reg_idx_t r;
    r = r.first();
    do begin
      reg_write(r, pick_reg_value());
      r = r.next();
    end while (r != r.first());
  endtask

  initial begin
    req_ch.valid          = 1'b0;
    req_ch.payload_length = 16'd0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    tx_quiet              = 1'b0;
    rx_quiet              = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // registers still at their reset value
    send_length(16'd0);
    send_length(16'hFFFF);
    drain();

    // every register at its maximum, upper bits of the bus set as well
    reg_write(uhb_pkg::REG_SRC_MAC, '1);
    reg_write(uhb_pkg::REG_DST_MAC, '1);
    reg_write(uhb_pkg::REG_SRC_IP, '1);
    reg_write(uhb_pkg::REG_DST_IP, '1);
    reg_write(uhb_pkg::REG_SRC_PORT, '1);
    reg_write(uhb_pkg::REG_DST_PORT, '1);
    // unmapped indexes must leave the configuration alone
    reg_write(SPARE_REG_LO, '0);
    reg_write(SPARE_REG_HI, '0);
    send_length(16'd0);
    send_length(16'd1);
    send_length(MAX_PAYLOAD);
    send_length(MAX_PAYLOAD + 16'd1);
    send_length(16'hFFFF);
    send_length(16'h5555);
    send_length(16'hAAAA);
    send_length(16'h00FF);
    send_length(16'hFF00);
    drain();

    reg_write(uhb_pkg::REG_SRC_MAC, '0);
    reg_write(uhb_pkg::REG_DST_MAC, '0);
    reg_write(uhb_pkg::REG_SRC_IP, '0);
    reg_write(uhb_pkg::REG_DST_IP, '0);
    reg_write(uhb_pkg::REG_SRC_PORT, '0);
    reg_write(uhb_pkg::REG_DST_PORT, '0);
    reg_write(SPARE_REG_LO, '1);
    reg_write(SPARE_REG_HI, '1);
    send_length(16'd0);
    send_length(MAX_PAYLOAD);
    send_length(16'hFFFF);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      tx_quiet = (phase == 1) || (phase == 4);
      rx_quiet <= (phase == 2) || (phase == 4);
      load_random_config();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_length(pick_length());
        // now and then hold off until the header line has emptied
        if ($urandom_range(0, 24) == 0)
          drain();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
